// File: rtl/srbp_pkg.sv
// Shared types, constants and helpers of the sensor report bit packer.
`default_nettype none
package srbp_pkg;

	localparam int PAYLOAD_BYTES_DEF = 51;
	localparam int HDR_BYTES         = 8;
	localparam int GRP_BYTES         = 8;
	localparam int ACC_W             = 24;
	localparam int OFS_W             = 16;

	localparam logic [15:0] THR_1H  = 16'd60;
	localparam logic [15:0] THR_2H  = 16'd120;
	localparam logic [15:0] THR_4H  = 16'd240;
	localparam logic [15:0] THR_8H  = 16'd480;
	localparam logic [15:0] THR_17H = 16'd1020;

	// floor(x / 15) = (x * DIV15_MAGIC) >> 35 for any 32-bit x
	localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;

	localparam logic [15:0] RST_INTERVAL = 16'd60;
	localparam logic [4:0]  RST_BITS_1H  = 5'd6;
	localparam logic [4:0]  RST_BITS_2H  = 5'd7;
	localparam logic [4:0]  RST_BITS_4H  = 5'd8;
	localparam logic [4:0]  RST_BITS_8H  = 5'd9;
	localparam logic [4:0]  RST_BITS_17H = 5'd10;

	typedef enum logic [2:0] {
		REG_INTERVAL = 3'd0,
		REG_BITS_1H  = 3'd1,
		REG_BITS_2H  = 3'd2,
		REG_BITS_4H  = 3'd3,
		REG_BITS_8H  = 3'd4,
		REG_BITS_17H = 3'd5
	} reg_idx_t;

	typedef enum logic {
		MODE_HEADER = 1'b0,
		MODE_OFFSET = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  event_count;
		logic [2:0]  status_code;
		logic [3:0]  hw_version;
		logic [3:0]  sw_version;
		logic [4:0]  battery_code;
		logic [4:0]  temperature_code;
		logic [2:0]  humidity_code;
		logic [4:0]  hour_of_day;
		logic [31:0] device_seconds;
		logic [15:0] minute_offset;
	} item_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
		logic       overflow;
	} result_t;

	typedef struct packed {
		logic [15:0]     interval_minutes;
		logic [4:0][4:0] bits_w;
	} cfg_t;

	// One item's worth of output bytes, handed to the serializer
	typedef struct packed {
		result_t [GRP_BYTES-1:0] bytes;
		logic [3:0]              cnt;
	} grp_t;

	function automatic logic [2:0] interval_index(input logic [15:0] mins);
		logic [2:0] idx;
		if (mins <= THR_1H)
			idx = 3'd0;
		else if (mins <= THR_2H)
			idx = 3'd1;
		else if (mins <= THR_4H)
			idx = 3'd2;
		else if (mins <= THR_8H)
			idx = 3'd3;
		else
			idx = 3'd4;
		return idx;
	endfunction

	function automatic logic [4:0] clamp_width(input logic [4:0] w);
		logic [4:0] r;
		if (w == 5'd0)
			r = 5'd1;
		else if (w > 5'd16)
			r = 5'd16;
		else
			r = w;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/srbp_core.sv
// Packing stage: header bytes, bit accumulator and payload limit for one item.
`default_nettype none
module srbp_core import srbp_pkg::*; #(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  item_t item,
	input  wire   take,
	input  cfg_t  cfg,
	output grp_t  grp
);

	localparam int BW = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [BW-1:0] PAY_LIM  = BW'(PAYLOAD_BYTES);
	localparam logic [BW-1:0] PAY_LAST = BW'(PAYLOAD_BYTES - 1);
	localparam logic [BW-1:0] HDR_CNT  = BW'(HDR_BYTES);
	localparam logic [BW-1:0] ONE      = BW'(1);

	logic [ACC_W-1:0] acc_q, acc_d;
	logic [4:0]       held_q, held_d;
	logic [7:0]       left_q, left_d;
	logic [BW-1:0]    sent_q, sent_d;

	logic [2:0]  idx;
	logic [4:0]  w;
	logic [63:0] prod;
	logic [23:0] minutes;

	assign idx     = interval_index(cfg.interval_minutes);
	assign w       = clamp_width(cfg.bits_w[idx]);
	assign prod    = {32'd0, 2'b00, item.device_seconds[31:2]} * {32'd0, DIV15_MAGIC};
	assign minutes = prod[58:35];

	always_comb begin
		logic [ACC_W-1:0] acc;
		logic [4:0]       held;
		logic [4:0]       rest;
		logic [BW-1:0]    bs;
		logic [3:0]       n;
		logic [15:0]      mask;
		logic             fin;
		logic             more;
		grp    = '0;
		acc_d  = acc_q;
		held_d = held_q;
		left_d = left_q;
		sent_d = sent_q;
		acc    = acc_q;
		held   = held_q;
		bs     = sent_q;
		n      = 4'd0;
		rest   = 5'd0;
		more   = 1'b0;
		mask   = 16'((17'd1 << w) - 17'd1);
		fin    = 1'b0;
		if (item.mode == MODE_HEADER) begin
			grp.bytes[0] = '{item.event_count, 1'b0, 1'b0};
			grp.bytes[1] = '{{item.hw_version, item.sw_version}, 1'b0, 1'b0};
			grp.bytes[2] = '{{item.battery_code, item.status_code}, 1'b0, 1'b0};
			grp.bytes[3] = '{{item.humidity_code, item.temperature_code}, 1'b0, 1'b0};
			grp.bytes[4] = '{{item.hour_of_day, idx}, 1'b0, 1'b0};
			grp.bytes[5] = '{minutes[7:0], 1'b0, 1'b0};
			grp.bytes[6] = '{minutes[15:8], 1'b0, 1'b0};
			grp.bytes[7] = '{minutes[23:16], item.event_count == 8'd0, 1'b0};
			grp.cnt      = 4'(HDR_BYTES);
			acc_d        = '0;
			held_d       = 5'd0;
			left_d       = item.event_count;
			sent_d       = HDR_CNT;
		end else if (left_q != 8'd0) begin
			acc  = acc | (ACC_W'(item.minute_offset & mask) << held);
			held = held + w;
			fin  = (left_q == 8'd1);
			for (int k = 0; k < 3; k++) begin
				if (held >= 5'd8 || (fin && held != 5'd0)) begin
					rest = (held >= 5'd8) ? held - 5'd8 : 5'd0;
					more = (rest != 5'd0) || !fin;
					if (bs < PAY_LIM) begin
						grp.bytes[n[2:0]] = '{acc[7:0], !more || (bs == PAY_LAST),
							more && (bs == PAY_LAST)};
						n  = n + 4'd1;
						bs = bs + ONE;
					end
					acc  = acc >> 8;
					held = rest;
				end
			end
			grp.cnt = n;
			acc_d   = fin ? '0 : acc;
			held_d  = fin ? 5'd0 : held;
			left_d  = left_q - 8'd1;
			sent_d  = bs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= 5'd0;
			left_q <= 8'd0;
			sent_q <= '0;
		end else if (take) begin
			acc_q  <= acc_d;
			held_q <= held_d;
			left_q <= left_d;
			sent_q <= sent_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/srbp_ser.sv
// Output serializer: holds one group of bytes and hands them out one per cycle while result_stall is low.
`default_nettype none
module srbp_ser import srbp_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  grp_t    grp,
	input  wire     load,
	output wire     free,
	output result_t result,
	output wire     result_valid,
	input  wire     result_stall
);

	grp_t       grp_s2;
	logic       vld_q;
	logic [2:0] idx_q;
	logic       done;

	assign done         = vld_q && !result_stall && ({1'b0, idx_q} == grp_s2.cnt - 4'd1);
	assign free         = !vld_q || done;
	assign result       = grp_s2.bytes[idx_q];
	assign result_valid = vld_q;

	always_ff @(posedge clk) begin
		if (load && free)
			grp_s2 <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (free) begin
			vld_q <= load;
			idx_q <= 3'd0;
		end else if (!result_stall) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sensor_report_bit_packer.sv
// Top level of the sensor report bit packer: input register, config registers, glue.
//
// A header item produces the eight header bytes; a minute offset item produces zero to
// three payload bytes. Bytes leave one per cycle on the result channel unless it is
// stalled; the serializer's group register sets that pace. A new input item is taken
// in each cycle in which the serializer is free or hands out its group's last byte, and
// an item's first byte is presented once it has passed the input and group registers.
// Configuration writes are always ready and take effect on the next item.
`default_nettype none
module sensor_report_bit_packer import srbp_pkg::*; #(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output wire        item_stall,
	input  item_t      item,
	output wire        result_valid,
	input  wire        result_stall,
	output result_t    result,
	input  wire        cfg_valid,
	output wire        cfg_ready,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_data
);

	item_t item_s1;
	logic  vld_s1;
	cfg_t  cfg_q;
	grp_t  grp;
	logic  free;
	logic  adv;

	assign adv        = free || !vld_s1;
	assign item_stall = !adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk) begin
		if (adv && item_valid)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= item_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_minutes <= RST_INTERVAL;
			cfg_q.bits_w[0]        <= RST_BITS_1H;
			cfg_q.bits_w[1]        <= RST_BITS_2H;
			cfg_q.bits_w[2]        <= RST_BITS_4H;
			cfg_q.bits_w[3]        <= RST_BITS_8H;
			cfg_q.bits_w[4]        <= RST_BITS_17H;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INTERVAL: cfg_q.interval_minutes <= cfg_data;
				REG_BITS_1H:  cfg_q.bits_w[0]        <= cfg_data[4:0];
				REG_BITS_2H:  cfg_q.bits_w[1]        <= cfg_data[4:0];
				REG_BITS_4H:  cfg_q.bits_w[2]        <= cfg_data[4:0];
				REG_BITS_8H:  cfg_q.bits_w[3]        <= cfg_data[4:0];
				REG_BITS_17H: cfg_q.bits_w[4]        <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	srbp_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_s1),
		.take  (vld_s1 && free),
		.cfg   (cfg_q),
		.grp   (grp)
	);

	srbp_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp         (grp),
		.load        (vld_s1 && grp.cnt != 4'd0),
		.free        (free),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
`default_nettype wire
